### hw/rtl/vmu_pkg.sv
// vmu_pkg: shared types, constants and arithmetic helpers for the 3D vector unit.
// Used by the interfaces, the lane, merge, square root and divider stages and the top level.
// No dependencies.
package vmu_pkg;

  localparam int DATA_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_LANES  = 3;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int RAD_W      = PROD_W;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SQ_REM_W   = ROOT_W + 4;
  localparam int SQ_STAGES  = ROOT_W;
  localparam int QUO_W      = FRAC_BITS + 1;
  localparam int DIV_NUM_W  = DATA_W + FRAC_BITS;
  localparam int DIV_STAGES = QUO_W;

  localparam logic [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    FN_ADD   = 3'd0,
    FN_SUB   = 3'd1,
    FN_DOT   = 3'd2,
    FN_CROSS = 3'd3,
    FN_MAG   = 3'd4,
    FN_DIST  = 3'd5,
    FN_NORM  = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    FLT_NONE = 2'd0,
    FLT_SAT  = 2'd1,
    FLT_ZERO = 2'd2
  } fault_t;

  // per-component results of one lane
  typedef struct packed {
    logic signed [PROD_W-1:0] p_dot;
    logic signed [PROD_W-1:0] p_c1;
    logic signed [PROD_W-1:0] p_c2;
    logic [RAD_W-1:0]         sq;
    logic [DATA_W-1:0]        sum;
    logic                     sat;
    logic                     big;
    logic                     neg;
    logic [DATA_W-1:0]        u;
  } lane_t;

  // sideband that rides along the root and divide pipelines
  typedef struct packed {
    func_t                              func;
    fault_t                             fault;
    logic [DATA_W-1:0]                  res_x;
    logic [DATA_W-1:0]                  res_y;
    logic [DATA_W-1:0]                  res_z;
    logic [DATA_W-1:0]                  res_s;
    logic [NUM_LANES-1:0][DATA_W-1:0]   u;
    logic [NUM_LANES-1:0]               neg;
    logic                               big;
    logic                               zero;
    logic [ROOT_W-1:0]                  mag;
  } side_t;

  typedef struct packed {
    side_t               side;
    logic [RAD_W-1:0]    n;
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
  } sq_st_t;

  typedef struct packed {
    side_t                                side;
    logic [NUM_LANES-1:0][DIV_NUM_W-1:0]  rem;
    logic [NUM_LANES-1:0][QUO_W-1:0]      q;
  } div_st_t;

  typedef struct packed {
    logic              ovf;
    logic [DATA_W-1:0] val;
  } sat_t;

  // arithmetic shift right by FRAC_BITS, then clamp to DATA_W signed bits
  function automatic sat_t sat_shift(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] sh;
    sat_t r;
    sh = v >>> FRAC_BITS;
    if ((&sh[ACC_W-1:DATA_W-1]) || !(|sh[ACC_W-1:DATA_W-1])) begin
      r.ovf = 1'b0;
      r.val = sh[DATA_W-1:0];
    end else begin
      r.ovf = 1'b1;
      r.val = sh[ACC_W-1] ? S_MIN : S_MAX;
    end
    return r;
  endfunction

  // one result bit of the digit-by-digit integer square root
  function automatic sq_st_t sq_step(input sq_st_t s);
    sq_st_t r;
    logic [SQ_REM_W-1:0] rem2;
    logic [SQ_REM_W-1:0] trial;
    r     = s;
    rem2  = {s.rem[SQ_REM_W-3:0], s.n[RAD_W-1 -: 2]};
    trial = {{(SQ_REM_W-ROOT_W-2){1'b0}}, s.root, 2'b01};
    r.n   = {s.n[RAD_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      r.rem  = rem2 - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = rem2;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // one quotient bit (weight 2^j) for all three components
  function automatic div_st_t div_step(input div_st_t s, input int j);
    div_st_t r;
    logic [DIV_NUM_W-1:0] dsh;
    r   = s;
    dsh = DIV_NUM_W'(s.side.mag) << j;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (s.rem[i] >= dsh) begin
        r.rem[i] = s.rem[i] - dsh;
        r.q[i]   = {s.q[i][QUO_W-2:0], 1'b1};
      end else begin
        r.q[i]   = {s.q[i][QUO_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

### hw/rtl/vmu_req_if.sv
// vmu_req_if: request channel of the vector unit (operation and two vectors).
// Depends on vmu_pkg.
interface vmu_req_if;
  import vmu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [2:0]               func;
  logic signed [DATA_W-1:0] a_x;
  logic signed [DATA_W-1:0] a_y;
  logic signed [DATA_W-1:0] a_z;
  logic signed [DATA_W-1:0] b_x;
  logic signed [DATA_W-1:0] b_y;
  logic signed [DATA_W-1:0] b_z;
  modport source (output valid, func, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
  modport sink (input valid, func, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

### hw/rtl/vmu_rsp_if.sv
// vmu_rsp_if: result channel of the vector unit (vector, scalar and fault code).
// Depends on vmu_pkg.
interface vmu_rsp_if;
  import vmu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] res_x;
  logic signed [DATA_W-1:0] res_y;
  logic signed [DATA_W-1:0] res_z;
  logic signed [DATA_W-1:0] res_scalar;
  logic [1:0]               fault;
  modport source (output valid, res_x, res_y, res_z, res_scalar, fault, input ready);
  modport sink (input valid, res_x, res_y, res_z, res_scalar, fault, output ready);
endinterface

### hw/rtl/vmu_lane.sv
// vmu_lane: one vector component: saturating add/sub, the products for dot and cross,
// and the square used by length operations. One register stage. Depends on vmu_pkg.
module vmu_lane (
  input  logic                              clk,
  input  logic                              en,
  input  vmu_pkg::func_t                    func,
  input  logic signed [vmu_pkg::DATA_W-1:0] a,
  input  logic signed [vmu_pkg::DATA_W-1:0] b,
  input  logic signed [vmu_pkg::DATA_W-1:0] m1a,
  input  logic signed [vmu_pkg::DATA_W-1:0] m1b,
  input  logic signed [vmu_pkg::DATA_W-1:0] m2a,
  input  logic signed [vmu_pkg::DATA_W-1:0] m2b,
  output vmu_pkg::lane_t                    res
);
  import vmu_pkg::*;

  logic signed [DATA_W:0]     s;
  logic signed [DATA_W:0]     op;
  logic signed [2*DATA_W+1:0] sq_full;
  lane_t                      nx;

  always_comb begin
    if (func == FN_SUB) begin
      s = (DATA_W+1)'(a) - (DATA_W+1)'(b);
    end else begin
      s = (DATA_W+1)'(a) + (DATA_W+1)'(b);
    end
    if (func == FN_DIST) begin
      op = (DATA_W+1)'(a) - (DATA_W+1)'(b);
    end else begin
      op = (DATA_W+1)'(a);
    end
    sq_full  = op * op;
    nx.p_dot = a * b;
    nx.p_c1  = m1a * m1b;
    nx.p_c2  = m2a * m2b;
    nx.sq    = sq_full[RAD_W-1:0];
    nx.sat   = s[DATA_W] ^ s[DATA_W-1];
    if (nx.sat) begin
      nx.sum = s[DATA_W] ? S_MIN : S_MAX;
    end else begin
      nx.sum = s[DATA_W-1:0];
    end
    // magnitude of 2^31 or more
    nx.big = (!op[DATA_W] && op[DATA_W-1]) ||
             (op[DATA_W] && (!op[DATA_W-1] || op[DATA_W-2:0] == '0));
    nx.neg = a[DATA_W-1];
    nx.u   = a[DATA_W-1] ? DATA_W'(DATA_W'(0) - a) : DATA_W'(a);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= nx;
    end
  end

endmodule

### hw/rtl/vmu_merge.sv
// vmu_merge: combines the three lanes: dot sum, cross differences, sum of squares,
// saturation and fault code. One register stage. Depends on vmu_pkg.
module vmu_merge (
  input  logic                                      clk,
  input  logic                                      en,
  input  vmu_pkg::func_t                            func,
  input  vmu_pkg::lane_t [vmu_pkg::NUM_LANES-1:0]   lanes,
  output vmu_pkg::sq_st_t                           res
);
  import vmu_pkg::*;

  logic signed [ACC_W-1:0]   dot;
  logic signed [PROD_W:0]    cr [NUM_LANES];
  sat_t                      dot_s;
  sat_t                      cr_s [NUM_LANES];
  logic [RAD_W-1:0]          sumsq;
  side_t                     side;

  always_comb begin
    dot = ACC_W'(lanes[0].p_dot) + ACC_W'(lanes[1].p_dot) + ACC_W'(lanes[2].p_dot);
    dot_s = sat_shift(dot);
    for (int i = 0; i < NUM_LANES; i++) begin
      cr[i]   = (PROD_W+1)'(lanes[i].p_c1) - (PROD_W+1)'(lanes[i].p_c2);
      cr_s[i] = sat_shift(ACC_W'(cr[i]));
    end
    sumsq = lanes[0].sq + lanes[1].sq + lanes[2].sq;

    side      = '0;
    side.func = func;
    case (func)
      FN_ADD, FN_SUB: begin
        side.res_x = lanes[0].sum;
        side.res_y = lanes[1].sum;
        side.res_z = lanes[2].sum;
        if (lanes[0].sat || lanes[1].sat || lanes[2].sat) side.fault = FLT_SAT;
      end
      FN_DOT: begin
        side.res_s = dot_s.val;
        if (dot_s.ovf) side.fault = FLT_SAT;
      end
      FN_CROSS: begin
        side.res_x = cr_s[0].val;
        side.res_y = cr_s[1].val;
        side.res_z = cr_s[2].val;
        if (cr_s[0].ovf || cr_s[1].ovf || cr_s[2].ovf) side.fault = FLT_SAT;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < NUM_LANES; i++) begin
      side.u[i]   = lanes[i].u;
      side.neg[i] = lanes[i].neg;
    end
    side.big  = lanes[0].big || lanes[1].big || lanes[2].big;
    side.zero = (sumsq == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.side <= side;
      res.n    <= sumsq;
      res.rem  <= '0;
      res.root <= '0;
    end
  end

endmodule

### hw/rtl/vmu_sqrt.sv
// vmu_sqrt: pipelined integer square root, one result bit per stage, with sideband.
// Depends on vmu_pkg.
module vmu_sqrt (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  vmu_pkg::sq_st_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output vmu_pkg::sq_st_t  out_data
);
  import vmu_pkg::*;

  logic [SQ_STAGES-1:0] vld;
  logic [SQ_STAGES:0]   en;
  sq_st_t               st [SQ_STAGES];
  sq_st_t               nx [SQ_STAGES];

  always_comb begin
    en[SQ_STAGES] = out_ready;
    for (int k = SQ_STAGES - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
    nx[0] = sq_step(in_data);
    for (int k = 1; k < SQ_STAGES; k++) begin
      nx[k] = sq_step(st[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < SQ_STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (en[k]) st[k] <= nx[k];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[SQ_STAGES-1];
  assign out_data  = st[SQ_STAGES-1];

endmodule

### hw/rtl/vmu_div.sv
// vmu_div: pipelined restoring divider for normalize, three components side by side,
// one quotient bit per stage, with sideband. Depends on vmu_pkg.
module vmu_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  vmu_pkg::div_st_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output vmu_pkg::div_st_t  out_data
);
  import vmu_pkg::*;

  logic [DIV_STAGES-1:0] vld;
  logic [DIV_STAGES:0]   en;
  div_st_t               st [DIV_STAGES];
  div_st_t               nx [DIV_STAGES];

  always_comb begin
    en[DIV_STAGES] = out_ready;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
    nx[0] = div_step(in_data, FRAC_BITS);
    for (int k = 1; k < DIV_STAGES; k++) begin
      nx[k] = div_step(st[k-1], FRAC_BITS - k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < DIV_STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (en[k]) st[k] <= nx[k];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[DIV_STAGES-1];
  assign out_data  = st[DIV_STAGES-1];

endmodule

### hw/rtl/vector3_math_unit.sv
// vector3_math_unit: top level of the 3D vector unit (lanes, merge, root, divide, output).
// Depends on vmu_pkg, vmu_req_if, vmu_rsp_if, vmu_lane, vmu_merge, vmu_sqrt, vmu_div.
//
// Fully pipelined: one request is taken every cycle while the result side does not stall,
// and every request yields one result, in order. Every operation takes the same path
// (Q16.16 data): input register, lane multipliers, merge, a 32-stage square root (one root
// bit per stage) and a FRAC_BITS+1 stage divider (one quotient bit per stage), then the
// output register. Stalls on the result side fill pipeline bubbles before the request
// side sees backpressure.
module vector3_math_unit (
  input  logic       clk,
  input  logic       rst,
  vmu_req_if.sink    req,
  vmu_rsp_if.source  rsp
);
  import vmu_pkg::*;

  // input register
  logic                     v0;
  func_t                    func0;
  logic signed [DATA_W-1:0] a0 [NUM_LANES];
  logic signed [DATA_W-1:0] b0 [NUM_LANES];
  // lane and merge stages
  logic                     v1;
  func_t                    func1;
  lane_t [NUM_LANES-1:0]    lane_q;
  logic                     v2;
  sq_st_t                   mg_q;
  logic                     en0, en1, en2;
  // root and divide
  logic                     sq_in_ready;
  logic                     sq_out_valid;
  sq_st_t                   sq_out;
  logic                     dv_in_ready;
  div_st_t                  dv_in;
  logic                     dv_out_valid;
  div_st_t                  dv_out;
  // output register
  logic                     en_out;
  logic                     valid_o;
  func_t                    func_o;
  logic [DATA_W-1:0]        rx_next, ry_next, rz_next, rs_next;
  fault_t                   fault_next;
  logic [DATA_W-1:0]        res_x, res_y, res_z, res_s;
  fault_t                   fault;

  assign en2       = !v2 || sq_in_ready;
  assign en1       = !v1 || en2;
  assign en0       = !v0 || en1;
  assign req.ready = en0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en0) v0 <= req.valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      func0 <= func_t'(req.func);
      a0[0] <= req.a_x;
      a0[1] <= req.a_y;
      a0[2] <= req.a_z;
      b0[0] <= req.b_x;
      b0[1] <= req.b_y;
      b0[2] <= req.b_z;
    end
    if (en1) func1 <= func0;
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    vmu_lane u_lane (
      .clk  (clk),
      .en   (en1),
      .func (func0),
      .a    (a0[i]),
      .b    (b0[i]),
      .m1a  (a0[(i+1)%NUM_LANES]),
      .m1b  (b0[(i+2)%NUM_LANES]),
      .m2a  (b0[(i+1)%NUM_LANES]),
      .m2b  (a0[(i+2)%NUM_LANES]),
      .res  (lane_q[i])
    );
  end

  vmu_merge u_merge (
    .clk   (clk),
    .en    (en2),
    .func  (func1),
    .lanes (lane_q),
    .res   (mg_q)
  );

  vmu_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (sq_in_ready),
    .in_data   (mg_q),
    .out_valid (sq_out_valid),
    .out_ready (dv_in_ready),
    .out_data  (sq_out)
  );

  always_comb begin
    dv_in.side     = sq_out.side;
    dv_in.side.mag = sq_out.root;
    for (int i = 0; i < NUM_LANES; i++) begin
      dv_in.rem[i] = {sq_out.side.u[i], {FRAC_BITS{1'b0}}};
      dv_in.q[i]   = '0;
    end
  end

  vmu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_out_valid),
    .in_ready  (dv_in_ready),
    .in_data   (dv_in),
    .out_valid (dv_out_valid),
    .out_ready (en_out),
    .out_data  (dv_out)
  );

  // final selection per operation
  always_comb begin
    rx_next    = dv_out.side.res_x;
    ry_next    = dv_out.side.res_y;
    rz_next    = dv_out.side.res_z;
    rs_next    = dv_out.side.res_s;
    fault_next = dv_out.side.fault;
    case (dv_out.side.func)
      FN_MAG, FN_DIST: begin
        if (dv_out.side.big || dv_out.side.mag[ROOT_W-1]) begin
          rs_next    = S_MAX;
          fault_next = FLT_SAT;
        end else begin
          rs_next    = DATA_W'(dv_out.side.mag);
        end
      end
      FN_NORM: begin
        if (dv_out.side.zero) begin
          rx_next    = '0;
          ry_next    = '0;
          rz_next    = '0;
          fault_next = FLT_ZERO;
        end else begin
          rx_next = dv_out.side.neg[0] ? DATA_W'(0) - DATA_W'(dv_out.q[0])
                                       : DATA_W'(dv_out.q[0]);
          ry_next = dv_out.side.neg[1] ? DATA_W'(0) - DATA_W'(dv_out.q[1])
                                       : DATA_W'(dv_out.q[1]);
          rz_next = dv_out.side.neg[2] ? DATA_W'(0) - DATA_W'(dv_out.q[2])
                                       : DATA_W'(dv_out.q[2]);
        end
      end
      default: begin
      end
    endcase
  end

  assign en_out = !valid_o || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en_out) begin
      valid_o <= dv_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      func_o <= dv_out.side.func;
      res_x  <= rx_next;
      res_y  <= ry_next;
      res_z  <= rz_next;
      res_s  <= rs_next;
      fault  <= fault_next;
    end
  end

  assign rsp.valid      = valid_o;
  assign rsp.res_x      = res_x;
  assign rsp.res_y      = res_y;
  assign rsp.res_z      = res_z;
  assign rsp.res_scalar = res_s;
  assign rsp.fault      = fault;

  a_zero_norm: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.fault == FLT_ZERO |->
      rsp.res_x == '0 && rsp.res_y == '0 && rsp.res_z == '0 && rsp.res_scalar == '0)
    else $error("zero-vector fault with nonzero result");

  a_scalar_ops: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (func_o == FN_DOT || func_o == FN_MAG || func_o == FN_DIST) |->
      rsp.res_x == '0 && rsp.res_y == '0 && rsp.res_z == '0)
    else $error("scalar op drove vector result");

  a_vector_ops: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (func_o == FN_ADD || func_o == FN_SUB || func_o == FN_CROSS ||
                  func_o == FN_NORM) |-> rsp.res_scalar == '0)
    else $error("vector op drove scalar result");

  a_len_sat: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (func_o == FN_MAG || func_o == FN_DIST) && rsp.fault == FLT_SAT |->
      rsp.res_scalar == S_MAX)
    else $error("saturated length not clamped");

endmodule
